@@ rtl/core/psopu_pkg.sv @@
package psopu_pkg;

   // Number of dimensions held for the particle.
   localparam int DIMS  = 64;
   localparam int IDX_W = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam int CNT_W = $clog2(DIMS + 1);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   // Request codes.
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_MOVE  = 2'd1;
   localparam logic [1:0] REQ_GRADE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VELOCITY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BOUND    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BOUND    = 3'd4;

   localparam logic signed [31:0] BEST_GRADE_RESET = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [5:0]         dim_index;
      logic signed [31:0] value_a;
      logic signed [31:0] value_b;
      logic [15:0]        rand_one;
      logic [15:0]        rand_two;
      logic signed [31:0] grade_value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] new_position;
      logic signed [31:0] new_velocity;
      logic               improved;
      logic signed [31:0] best_grade_out;
      logic               was_evaluated;
   } rsp_word_type;

   typedef struct packed {
      logic [20:0]        alpha_gain;
      logic [20:0]        beta_gain;
      logic [30:0]        max_velocity;
      logic signed [15:0] min_bound;
      logic signed [15:0] max_bound;
   } cfg_type;

   // Step of the shared arithmetic unit for a move.
   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_KG,
      STEP_KP,
      STEP_DG,
      STEP_DP,
      STEP_ACC,
      STEP_VEL
   } step_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REPLY,
      ST_LOAD,
      ST_KG,
      ST_KP,
      ST_DG,
      ST_DP,
      ST_ACC,
      ST_VEL,
      ST_POS,
      ST_GRADE,
      ST_COPY
   } state_type;

endpackage

@@ rtl/core/psopu_arith.sv @@
module psopu_arith (
   input  logic                     clock,
   input  psopu_pkg::step_type      step,
   input  psopu_pkg::cfg_type       cfg,
   input  logic signed [31:0]       global_best,
   input  logic [15:0]              rand_one,
   input  logic [15:0]              rand_two,
   input  logic signed [31:0]       pos_old,
   input  logic signed [31:0]       vel_old,
   input  logic signed [31:0]       pbest_old,
   output logic signed [31:0]       vel_new,
   output logic signed [31:0]       pos_new
);
   import psopu_pkg::*;

   logic signed [33:0] mul_a;
   logic signed [21:0] mul_b;
   logic signed [55:0] prod_in;
   logic signed [55:0] prod_ff;
   logic [20:0]        kg_ff;
   logic [20:0]        kp_ff;
   logic signed [55:0] acc_ff;
   logic signed [31:0] vel_ff;
   logic signed [31:0] vel_in;
   logic signed [33:0] diff_g;
   logic signed [33:0] diff_p;
   logic signed [40:0] vsum;
   logic signed [40:0] vmax;
   logic signed [32:0] psum;
   logic signed [32:0] pos_hi;
   logic signed [32:0] pos_lo;
   logic signed [32:0] pclamp;

   assign diff_g = {{2{global_best[31]}}, global_best} - {{2{pos_old[31]}}, pos_old};
   assign diff_p = {{2{pbest_old[31]}}, pbest_old} - {{2{pos_old[31]}}, pos_old};

   // The one multiplier: gain by random factor first, then difference by factor.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step)
         STEP_KG: begin
            mul_a = signed'({13'd0, cfg.alpha_gain});
            mul_b = signed'({6'd0, rand_one});
         end
         STEP_KP: begin
            mul_a = signed'({13'd0, cfg.beta_gain});
            mul_b = signed'({6'd0, rand_two});
         end
         STEP_DG: begin
            mul_a = diff_g;
            mul_b = signed'({1'b0, kg_ff});
         end
         STEP_DP: begin
            mul_a = diff_p;
            mul_b = signed'({1'b0, kp_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Velocity update with floor shift, then clamp to plus or minus the limit.
   always_comb begin
      vmax = signed'({10'd0, cfg.max_velocity});
      vsum = {{9{vel_old[31]}}, vel_old} + {acc_ff[55], acc_ff[55:16]};
      if (vsum > vmax) begin
         vel_in = vmax[31:0];
      end else if (vsum < -vmax) begin
         vel_in = 32'(-vmax);
      end else begin
         vel_in = vsum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (step)
         STEP_KP:  kg_ff  <= prod_ff[36:16];
         STEP_DG:  kp_ff  <= prod_ff[36:16];
         STEP_DP:  acc_ff <= prod_ff;
         STEP_ACC: acc_ff <= acc_ff + prod_ff;
         STEP_VEL: vel_ff <= vel_in;
         default: begin
         end
      endcase
   end

   // Upper bound is applied first, so crossed bounds settle on the lower one.
   always_comb begin
      pos_hi = {cfg.max_bound[15], cfg.max_bound, 16'd0};
      pos_lo = {cfg.min_bound[15], cfg.min_bound, 16'd0};
      psum   = {pos_old[31], pos_old} + {vel_ff[31], vel_ff};
      pclamp = psum;
      if (pclamp > pos_hi) begin
         pclamp = pos_hi;
      end
      if (pclamp < pos_lo) begin
         pclamp = pos_lo;
      end
   end

   assign vel_new = vel_ff;
   assign pos_new = pclamp[31:0];

endmodule

@@ rtl/core/pso_particle_update.sv @@
// Update engine for one particle of a swarm, Q16.16 per dimension. Pulse start
// while busy is low to hand over a word; exactly one result word follows on
// rsp_word, marked by rsp_valid for a single cycle, and it must be taken then.
// A load, an ignored request and a grade that does not improve are answered
// from ST_LOAD, ST_REPLY or ST_GRADE; a move takes four passes through one
// shared multiplier, an accumulate, the velocity clamp and the position
// clamp; an improving grade also copies the personal best from the position
// memory one entry per cycle. Busy stays high until the result word is shown.
// Configuration writes are taken at any edge with csr_we high.
module pso_particle_update (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  psopu_pkg::req_word_type              req_word,
   output logic                                 rsp_valid,
   output psopu_pkg::rsp_word_type              rsp_word,
   input  logic                                 csr_we,
   input  logic [psopu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psopu_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import psopu_pkg::*;

   state_type          state_ff, state_in;
   req_word_type       item_ff;
   cfg_type            cfg_ff;
   logic signed [31:0] best_ff, best_in;
   logic               eval_ff, eval_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   step_type           step;
   logic               dim_ok;

   logic signed [31:0] pos_mem [DIMS];
   logic signed [31:0] vel_mem [DIMS];
   logic signed [31:0] pb_mem  [DIMS];
   logic signed [31:0] pos_rd_ff, vel_rd_ff, pb_rd_ff;
   logic [IDX_W-1:0]   item_idx, rd_addr, pos_raddr, pb_waddr;
   logic               pos_we, vel_we, pb_we;
   logic signed [31:0] pos_wdata, vel_wdata, pb_wdata;
   logic signed [31:0] vel_new, pos_new;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign item_idx  = IDX_W'(item_ff.dim_index);
   assign dim_ok    = (32'(req_word.dim_index) < DIMS);
   assign rd_addr   = (state_ff == ST_IDLE) ? IDX_W'(req_word.dim_index) : item_idx;
   assign pos_raddr = (state_ff == ST_COPY) ? cnt_ff[IDX_W-1:0] : rd_addr;

   psopu_arith u_arith (
      .clock       (clock),
      .step        (step),
      .cfg         (cfg_ff),
      .global_best (item_ff.value_a),
      .rand_one    (item_ff.rand_one),
      .rand_two    (item_ff.rand_two),
      .pos_old     (pos_rd_ff),
      .vel_old     (vel_rd_ff),
      .pbest_old   (pb_rd_ff),
      .vel_new     (vel_new),
      .pos_new     (pos_new)
   );

   always_comb begin
      state_in     = state_ff;
      best_in      = best_ff;
      eval_in      = eval_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = '0;
      step         = STEP_NONE;
      pos_we       = 1'b0;
      vel_we       = 1'b0;
      pb_we        = 1'b0;
      pos_wdata    = item_ff.value_a;
      vel_wdata    = item_ff.value_b;
      pb_wdata     = item_ff.value_a;
      pb_waddr     = item_idx;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_word.req_type)
                  REQ_LOAD:  state_in = dim_ok ? ST_LOAD : ST_REPLY;
                  REQ_MOVE:  state_in = dim_ok ? ST_KG : ST_REPLY;
                  REQ_GRADE: state_in = ST_GRADE;
                  default:   state_in = ST_REPLY;
               endcase
            end
         end
         ST_REPLY: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_LOAD: begin
            pos_we                   = 1'b1;
            vel_we                   = 1'b1;
            pb_we                    = 1'b1;
            rsp_valid_in             = 1'b1;
            rsp_word_in.new_position = item_ff.value_a;
            rsp_word_in.new_velocity = item_ff.value_b;
            state_in                 = ST_IDLE;
         end
         ST_KG: begin
            step     = STEP_KG;
            state_in = ST_KP;
         end
         ST_KP: begin
            step     = STEP_KP;
            state_in = ST_DG;
         end
         ST_DG: begin
            step     = STEP_DG;
            state_in = ST_DP;
         end
         ST_DP: begin
            step     = STEP_DP;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            step     = STEP_ACC;
            state_in = ST_VEL;
         end
         ST_VEL: begin
            step     = STEP_VEL;
            state_in = ST_POS;
         end
         ST_POS: begin
            pos_we                   = 1'b1;
            vel_we                   = 1'b1;
            pos_wdata                = pos_new;
            vel_wdata                = vel_new;
            rsp_valid_in             = 1'b1;
            rsp_word_in.new_position = pos_new;
            rsp_word_in.new_velocity = vel_new;
            state_in                 = ST_IDLE;
         end
         ST_GRADE: begin
            eval_in = 1'b1;
            if (item_ff.grade_value < best_ff) begin
               best_in  = item_ff.grade_value;
               cnt_in   = '0;
               state_in = ST_COPY;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_COPY: begin
            // The position read issued last cycle lands in the entry before.
            if (cnt_ff != '0) begin
               pb_we    = 1'b1;
               pb_waddr = IDX_W'(cnt_ff - CNT_W'(1));
               pb_wdata = pos_rd_ff;
            end
            if (cnt_ff == CNT_W'(DIMS)) begin
               rsp_valid_in         = 1'b1;
               rsp_word_in.improved = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_word_in.best_grade_out = best_in;
      rsp_word_in.was_evaluated  = eval_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         best_ff      <= BEST_GRADE_RESET;
         eval_ff      <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         best_ff      <= best_in;
         eval_ff      <= eval_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (start && !busy) begin
         item_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_gain   <= 21'd65536;
         cfg_ff.beta_gain    <= 21'd65536;
         cfg_ff.max_velocity <= 31'd65536;
         cfg_ff.min_bound    <= -16'sd32768;
         cfg_ff.max_bound    <= 16'sd32767;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHA_GAIN:   cfg_ff.alpha_gain   <= csr_wdata[20:0];
            CSR_BETA_GAIN:    cfg_ff.beta_gain    <= csr_wdata[20:0];
            CSR_MAX_VELOCITY: cfg_ff.max_velocity <= csr_wdata[30:0];
            CSR_MIN_BOUND:    cfg_ff.min_bound    <= signed'(csr_wdata[15:0]);
            CSR_MAX_BOUND:    cfg_ff.max_bound    <= signed'(csr_wdata[15:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[item_idx] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (vel_we) begin
         vel_mem[item_idx] <= vel_wdata;
      end
      vel_rd_ff <= vel_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pb_we) begin
         pb_mem[pb_waddr] <= pb_wdata;
      end
      pb_rd_ff <= pb_mem[rd_addr];
   end

`ifndef ASSERT_OFF
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word shown while the engine is still busy");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not start the sequencer");

   a_improved_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.improved |->
         rsp_word.was_evaluated && (rsp_word.best_grade_out != BEST_GRADE_RESET))
      else $error("improvement reported without a stored grade");

   a_copy_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY |-> cnt_ff <= CNT_W'(DIMS))
      else $error("personal best copy ran past the last dimension");

   a_move_one_word: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POS |=> rsp_valid && !busy)
      else $error("move finished without exactly one result word");
`endif

endmodule

@@ dv/pso_particle_update_tb.sv @@
`timescale 1ns / 100ps

module pso_particle_update_tb;
   import psopu_pkg::*;

   // Request code that the block must ignore.
   localparam logic [1:0] REQ_IGNORED = 2'd3;

   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 68;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_word_type          req_word;
   logic                  rsp_valid;
   rsp_word_type          rsp_word;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   typedef struct {
      req_word_type w;
      bit           known;
      rsp_word_type want;
   } directed_row_type;

   // Particle state as the block should hold it.
   logic signed [31:0] dim_position [DIMS];
   logic signed [31:0] dim_velocity [DIMS];
   logic signed [31:0] dim_best     [DIMS];
   bit                 dim_loaded   [DIMS];
   logic signed [31:0] record_grade;
   bit                 graded;
   cfg_type            particle_cfg;

   rsp_word_type     replies_due [$];
   directed_row_type directed_rows [$];
   rsp_word_type     checked_reply;
   int               mismatch_count;
   int               burst_left;
   bit               steady_run;

   pso_particle_update dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatch_count++;
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
   endtask

   function automatic rsp_word_type update_particle(input req_word_type w);
      rsp_word_type r;
      longint signed p, v, kg, kp, acc, vmax, hi, lo;
      r = '0;
      case (w.req_type)
         REQ_LOAD: begin
            dim_position[w.dim_index] = w.value_a;
            dim_velocity[w.dim_index] = w.value_b;
            dim_best[w.dim_index]     = w.value_a;
            dim_loaded[w.dim_index]   = 1'b1;
            r.new_position = w.value_a;
            r.new_velocity = w.value_b;
         end
         REQ_MOVE: begin
            p    = dim_position[w.dim_index];
            kg   = (longint'(particle_cfg.alpha_gain) * longint'(w.rand_one)) >>> 16;
            kp   = (longint'(particle_cfg.beta_gain) * longint'(w.rand_two)) >>> 16;
            acc  = (longint'(w.value_a) - p) * kg + (longint'(dim_best[w.dim_index]) - p) * kp;
            v    = longint'(dim_velocity[w.dim_index]) + (acc >>> 16);
            vmax = longint'(particle_cfg.max_velocity);
            if (v > vmax) v = vmax;
            if (v < -vmax) v = -vmax;
            p  = p + v;
            hi = longint'(particle_cfg.max_bound) * 65536;
            lo = longint'(particle_cfg.min_bound) * 65536;
            // With crossed bounds the lower one wins.
            if (p > hi) p = hi;
            if (p < lo) p = lo;
            dim_velocity[w.dim_index] = v[31:0];
            dim_position[w.dim_index] = p[31:0];
            r.new_position = p[31:0];
            r.new_velocity = v[31:0];
         end
         REQ_GRADE: begin
            graded = 1'b1;
            if (w.grade_value < record_grade) begin
               dim_best     = dim_position;
               record_grade = w.grade_value;
               r.improved   = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.best_grade_out = record_grade;
      r.was_evaluated  = graded;
      return r;
   endfunction

   function automatic int next_gap();
      if (steady_run) return 0;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = $urandom_range(0, 15);
      // Now and then a longer gap, which may outlast a full best copy.
      return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
   endfunction

   function automatic logic [31:0] wide_value();
      int signed raw;
      raw = $urandom;
      return ($urandom_range(0, 1) == 1) ? raw : raw >>> $urandom_range(4, 15);
   endfunction

   // Moves only address dimensions that hold a loaded position.
   function automatic req_word_type random_word();
      req_word_type    w;
      int              pick;
      int              step;
      logic [5:0]      d;
      longint signed   lower;
      w.req_type    = REQ_LOAD;
      w.dim_index   = 6'($urandom);
      w.value_a     = wide_value();
      w.value_b     = wide_value();
      w.rand_one    = 16'($urandom);
      w.rand_two    = 16'($urandom);
      w.grade_value = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         for (int tries = 0; tries < 8 && w.req_type != REQ_MOVE; tries++) begin
            d = 6'($urandom);
            if (dim_loaded[d]) begin
               w.req_type  = REQ_MOVE;
               w.dim_index = d;
            end
         end
      end else if (pick < 70) begin
         w.req_type = REQ_GRADE;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            step  = $urandom_range(1, 1 << 20);
            lower = longint'(record_grade) - step;
            w.grade_value = (lower < -64'sd2147483648) ? record_grade : lower[31:0];
         end else if (pick < 65) begin
            w.grade_value = record_grade;
         end else begin
            w.grade_value = {1'b0, 31'($urandom)};
         end
      end else if (pick < 74) begin
         w.req_type = REQ_IGNORED;
      end
      return w;
   endfunction

   task automatic add_row(input req_word_type w, input bit known, input rsp_word_type want);
      directed_row_type row;
      row.w     = w;
      row.known = known;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   // Called just after a rising edge; returns at the edge that took the word
   // or after the following gap.
   task automatic issue_word(input req_word_type w, input bit known,
                             input rsp_word_type want);
      rsp_word_type predicted;
      int           gap;
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = update_particle(w);
      replies_due.push_back(known ? want : predicted);
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle_block();
      start <= 1'b0;
      while (replies_due.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (DIMS + 4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_ALPHA_GAIN:   particle_cfg.alpha_gain   = data[20:0];
         CSR_BETA_GAIN:    particle_cfg.beta_gain    = data[20:0];
         CSR_MAX_VELOCITY: particle_cfg.max_velocity = data[30:0];
         CSR_MIN_BOUND:    particle_cfg.min_bound    = data[15:0];
         CSR_MAX_BOUND:    particle_cfg.max_bound    = data[15:0];
         default: begin
         end
      endcase
   endtask

   task automatic program_phase(input int phase);
      logic [20:0] alpha, beta;
      logic [30:0] vmax;
      logic [15:0] lo, hi, swap;
      case (phase)
         1: begin
            alpha = 21'd1048576;
            beta  = 21'd1048576;
            vmax  = 31'h7FFF_FFFF;
            lo    = 16'h8000;
            hi    = 16'h7FFF;
         end
         2: begin
            alpha = '0;
            beta  = '0;
            vmax  = '0;
            lo    = '0;
            hi    = '0;
         end
         3: begin
            alpha = 21'd131072;
            beta  = 21'd32768;
            vmax  = 31'h0020_0000;
            lo    = 16'd10;
            hi    = -16'sd10;
         end
         default: begin
            alpha = 21'($urandom_range(0, 1048576));
            beta  = 21'($urandom_range(0, 1048576));
            vmax  = ($urandom_range(0, 1) == 1) ? 31'($urandom)
                                                : 31'($urandom_range(0, 1 << 20));
            lo    = 16'($urandom);
            hi    = 16'($urandom);
            if ($signed(lo) > $signed(hi) && $urandom_range(0, 3) != 0) begin
               swap = lo;
               lo   = hi;
               hi   = swap;
            end
         end
      endcase
      write_register(CSR_ALPHA_GAIN, {10'd0, alpha});
      write_register(CSR_BETA_GAIN, {10'd0, beta});
      write_register(CSR_MAX_VELOCITY, vmax);
      write_register(CSR_MIN_BOUND, {15'd0, lo});
      write_register(CSR_MAX_BOUND, {15'd0, hi});
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (replies_due.size() == 0) begin
            flag_mismatch("word with nothing outstanding", rsp_word.new_position, '0);
         end else begin
            checked_reply = replies_due.pop_front();
            if (rsp_word.new_position !== checked_reply.new_position)
               flag_mismatch("new_position", rsp_word.new_position,
                             checked_reply.new_position);
            if (rsp_word.new_velocity !== checked_reply.new_velocity)
               flag_mismatch("new_velocity", rsp_word.new_velocity,
                             checked_reply.new_velocity);
            if (rsp_word.improved !== checked_reply.improved)
               flag_mismatch("improved", {31'd0, rsp_word.improved},
                             {31'd0, checked_reply.improved});
            if (rsp_word.best_grade_out !== checked_reply.best_grade_out)
               flag_mismatch("best_grade_out", rsp_word.best_grade_out,
                             checked_reply.best_grade_out);
            if (rsp_word.was_evaluated !== checked_reply.was_evaluated)
               flag_mismatch("was_evaluated", {31'd0, rsp_word.was_evaluated},
                             {31'd0, checked_reply.was_evaluated});
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_word  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      mismatch_count = 0;
      burst_left     = 0;
      steady_run     = 1'b0;
      record_grade   = BEST_GRADE_RESET;
      graded         = 1'b0;
      particle_cfg.alpha_gain   = 21'd65536;
      particle_cfg.beta_gain    = 21'd65536;
      particle_cfg.max_velocity = 31'd65536;
      particle_cfg.min_bound    = 16'h8000;
      particle_cfg.max_bound    = 16'h7FFF;
      for (int i = 0; i < DIMS; i++) begin
         dim_position[i] = '0;
         dim_velocity[i] = '0;
         dim_best[i]     = '0;
         dim_loaded[i]   = 1'b0;
      end

      // Extremes of every field, each request kind, an ignored code and
      // grades that tie and improve.
      add_row({REQ_IGNORED, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
               32'hFFFF_FFFF}, 1'b1, {32'd0, 32'd0, 1'b0, 32'h7FFF_FFFF, 1'b0});
      add_row({REQ_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0, 32'd0},
              1'b1, {32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 1'b0});
      add_row({REQ_LOAD, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 16'd0, 32'd0},
              1'b1, {32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 1'b0});
      add_row({REQ_LOAD, 6'd21, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 32'd0},
              1'b1, {32'd0, 32'd0, 1'b0, 32'h7FFF_FFFF, 1'b0});
      add_row({REQ_LOAD, 6'd42, 32'h0001_0000, 32'hFFFF_0000, 16'd0, 16'd0, 32'd0},
              1'b1, {32'h0001_0000, 32'hFFFF_0000, 1'b0, 32'h7FFF_FFFF, 1'b0});
      add_row({REQ_GRADE, 6'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'h7FFF_FFFF},
              1'b1, {32'd0, 32'd0, 1'b0, 32'h7FFF_FFFF, 1'b1});
      add_row({REQ_MOVE, 6'd0, 32'h8000_0000, 32'd0, 16'hFFFF, 16'hFFFF, 32'd0}, 1'b0, '0);
      add_row({REQ_MOVE, 6'd63, 32'h7FFF_FFFF, 32'd0, 16'hFFFF, 16'hFFFF, 32'd0}, 1'b0, '0);
      add_row({REQ_MOVE, 6'd21, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0}, 1'b0, '0);
      add_row({REQ_MOVE, 6'd42, 32'h0005_0000, 32'd0, 16'hFFFF, 16'd0, 32'd0}, 1'b0, '0);
      add_row({REQ_GRADE, 6'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'hC000_0000},
              1'b1, {32'd0, 32'd0, 1'b1, 32'hC000_0000, 1'b1});
      add_row({REQ_GRADE, 6'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'hC000_0000},
              1'b1, {32'd0, 32'd0, 1'b0, 32'hC000_0000, 1'b1});
      add_row({REQ_MOVE, 6'd0, 32'd0, 32'd0, 16'h8000, 16'h8000, 32'd0}, 1'b0, '0);
      add_row({REQ_MOVE, 6'd42, 32'hFFFF_FFFF, 32'd0, 16'd0, 16'hFFFF, 32'd0}, 1'b0, '0);
      add_row({REQ_IGNORED, 6'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0},
              1'b1, {32'd0, 32'd0, 1'b0, 32'hC000_0000, 1'b1});
      add_row({REQ_LOAD, 6'd42, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0},
              1'b1, {32'd0, 32'd0, 1'b0, 32'hC000_0000, 1'b1});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         issue_word(directed_rows[i].w, directed_rows[i].known, directed_rows[i].want);
      end

      // Phase 0 keeps the values from reset; later phases rewrite every register
      // once the block has drained.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            settle_block();
            program_phase(phase);
         end
         steady_run = (phase % 3 == 2);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            issue_word(random_word(), 1'b0, '0);
         end
      end

      // The lowest grade last, since nothing can improve on it afterwards.
      issue_word({REQ_GRADE, 6'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'h8000_0000}, 1'b0, '0);
      issue_word({REQ_GRADE, 6'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'h8000_0000}, 1'b0, '0);

      settle_block();
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
